// ===== rtl/core/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg: shared types and constants for the region size lister
// Datapath operation codes, the status bundle and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gcs_pkg;

    // fixed field widths
    localparam int SIZE_W   = 7;   // room_size
    localparam int DIM_W    = 4;   // rows / cols registers
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;
    localparam int CFG_AW   = 1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_AW-1:0] REG_COLS = 1'd1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_LOAD      = 4'd0,
        OP_SCAN_RD   = 4'd1,
        OP_SCAN_TEST = 4'd2,
        OP_SCAN_ADV  = 4'd3,
        OP_POP_RD    = 4'd4,
        OP_POP_WAIT  = 4'd5,
        OP_NB_RD     = 4'd6,
        OP_NB_TEST   = 4'd7,
        OP_INS_RD    = 4'd8,
        OP_INS_CMP   = 4'd9,
        OP_EMIT_RD   = 4'd10,
        OP_EMIT_WAIT = 4'd11
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic frame_go;     // last cell request taken
        logic scan_open;    // scanned cell is open and unvisited
        logic scan_done;    // scan position is the final cell
        logic q_empty;      // flood queue drained
        logic nb_ok;        // neighbor in current direction is on the grid
        logic dir_last;     // current direction is the last one
        logic ins_zero;     // insertion slot reached the front
        logic ins_greater;  // stored size is larger than the new one
        logic emit_last;    // size being emitted closes the frame
        logic out_free;     // output register can take a size
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/gcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcs_ctrl: sequencer for the region size lister
// Steps the load, scan, flood, insertion sort and emit phases.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gcs_pkg::dp_status_t st,
    output gcs_pkg::dp_op_t         op,
    output logic                    load_ready
);
    import gcs_pkg::*;

    typedef enum logic [11:0] {
        S_LOAD      = 12'b0000_0000_0001,
        S_SCAN_RD   = 12'b0000_0000_0010,
        S_SCAN_TEST = 12'b0000_0000_0100,
        S_SCAN_ADV  = 12'b0000_0000_1000,
        S_POP_RD    = 12'b0000_0001_0000,
        S_POP_WAIT  = 12'b0000_0010_0000,
        S_NB_RD     = 12'b0000_0100_0000,
        S_NB_TEST   = 12'b0000_1000_0000,
        S_INS_RD    = 12'b0001_0000_0000,
        S_INS_CMP   = 12'b0010_0000_0000,
        S_EMIT_RD   = 12'b0100_0000_0000,
        S_EMIT_WAIT = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:      if (st.frame_go) state_next = S_SCAN_RD;
            S_SCAN_RD:   state_next = S_SCAN_TEST;
            S_SCAN_TEST: state_next = st.scan_open ? S_POP_RD : S_SCAN_ADV;
            S_SCAN_ADV:  state_next = st.scan_done ? S_EMIT_RD : S_SCAN_RD;
            S_POP_RD:    state_next = st.q_empty ? S_INS_RD : S_POP_WAIT;
            S_POP_WAIT:  state_next = S_NB_RD;
            S_NB_RD: begin
                if (st.nb_ok)         state_next = S_NB_TEST;
                else if (st.dir_last) state_next = S_POP_RD;
            end
            S_NB_TEST:   state_next = st.dir_last ? S_POP_RD : S_NB_RD;
            S_INS_RD:    state_next = st.ins_zero ? S_SCAN_ADV : S_INS_CMP;
            S_INS_CMP:   state_next = st.ins_greater ? S_INS_RD : S_SCAN_ADV;
            S_EMIT_RD:   state_next = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (st.out_free) state_next = st.emit_last ? S_LOAD : S_EMIT_RD;
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // operation per state
    always_comb begin
        case (state_reg)
            S_LOAD:      op = OP_LOAD;
            S_SCAN_RD:   op = OP_SCAN_RD;
            S_SCAN_TEST: op = OP_SCAN_TEST;
            S_SCAN_ADV:  op = OP_SCAN_ADV;
            S_POP_RD:    op = OP_POP_RD;
            S_POP_WAIT:  op = OP_POP_WAIT;
            S_NB_RD:     op = OP_NB_RD;
            S_NB_TEST:   op = OP_NB_TEST;
            S_INS_RD:    op = OP_INS_RD;
            S_INS_CMP:   op = OP_INS_CMP;
            S_EMIT_RD:   op = OP_EMIT_RD;
            S_EMIT_WAIT: op = OP_EMIT_WAIT;
            default:     op = OP_LOAD;
        endcase
    end

    assign load_ready = (state_reg == S_LOAD);

endmodule

`default_nettype wire

// ===== rtl/core/gcs_dp.sv =====
// ----------------------------------------------------------------------------
// gcs_dp: datapath of the region size lister
// Wall map, visited bits, flood queue, sorted size list and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_dp #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [gcs_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [gcs_pkg::DIM_W-1:0]     cfg_wdata,
    input  wire gcs_pkg::dp_op_t               op,
    input  wire logic                          in_valid,
    input  wire logic                          in_wall,
    input  wire logic                          in_last,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [gcs_pkg::SIZE_W-1:0]         out_size,
    output logic                               out_last,
    output gcs_pkg::dp_status_t                st
);
    import gcs_pkg::*;

    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int SIZE_CAP = (CELL_CAP + 1) / 2;
    localparam int IDX_W    = $clog2(CELL_CAP);
    localparam int LP_W     = IDX_W + 1;
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);
    localparam int QW       = RW + CW;
    localparam int SA_W     = $clog2(SIZE_CAP);
    localparam int SC_W     = $clog2(SIZE_CAP + 1);

    // configuration
    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] nr, nc;
    logic [LP_W-1:0]  total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_W'(8);
            cols_reg <= DIM_W'(8);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ROWS: rows_reg <= cfg_wdata;
                REG_COLS: cols_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // clamp geometry to 1..MAX
    always_comb begin
        nr = rows_reg;
        if (rows_reg == '0) nr = DIM_W'(1);
        else if (rows_reg > DIM_W'(MAX_ROWS)) nr = DIM_W'(MAX_ROWS);
        nc = cols_reg;
        if (cols_reg == '0) nc = DIM_W'(1);
        else if (cols_reg > DIM_W'(MAX_COLS)) nc = DIM_W'(MAX_COLS);
    end
    assign total = LP_W'(nr) * LP_W'(nc);

    // storage
    logic             wall_mem [CELL_CAP];
    logic [QW-1:0]    queue_mem [CELL_CAP];
    logic [SIZE_W-1:0] size_mem [SIZE_CAP];
    logic [CELL_CAP-1:0] visited_reg;

    logic [LP_W-1:0]   load_pos_reg;
    logic [RW-1:0]     scan_r_reg, cur_r_reg, cand_r_reg;
    logic [CW-1:0]     scan_c_reg, cur_c_reg, cand_c_reg;
    logic [LP_W-1:0]   head_reg, tail_reg;
    logic [QW-1:0]     q_rd_reg;
    logic              wall_rd_reg;
    logic [1:0]        dir_reg;
    logic [SIZE_W-1:0] region_size_reg, sz_rd_reg;
    logic [SC_W-1:0]   count_reg, k_reg, emit_reg;

    logic              accept;
    logic [IDX_W-1:0]  scan_idx, cand_idx, cand_reg_idx;
    logic [RW-1:0]     nb_r;
    logic [CW-1:0]     nb_c;
    logic              nb_ok;
    logic              scan_open, nb_open, emit_last, out_free, emit_empty;

    assign accept = in_valid && (op == OP_LOAD);

    // neighbor in current direction: right, left, up, down
    always_comb begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            2'd0: begin
                nb_ok = (DIM_W'(cur_c_reg) + DIM_W'(1)) < nc;
                nb_c  = cur_c_reg + CW'(1);
            end
            2'd1: begin
                nb_ok = (cur_c_reg != '0);
                nb_c  = cur_c_reg - CW'(1);
            end
            2'd2: begin
                nb_ok = (cur_r_reg != '0);
                nb_r  = cur_r_reg - RW'(1);
            end
            2'd3: begin
                nb_ok = (DIM_W'(cur_r_reg) + DIM_W'(1)) < nr;
                nb_r  = cur_r_reg + RW'(1);
            end
            default: ;
        endcase
    end

    // row-major cell indexes
    assign scan_idx     = IDX_W'(scan_r_reg) * IDX_W'(nc) + IDX_W'(scan_c_reg);
    assign cand_idx     = IDX_W'(nb_r) * IDX_W'(nc) + IDX_W'(nb_c);
    assign cand_reg_idx = IDX_W'(cand_r_reg) * IDX_W'(nc) + IDX_W'(cand_c_reg);

    assign scan_open  = !wall_rd_reg && !visited_reg[scan_idx];
    assign nb_open    = !wall_rd_reg && !visited_reg[cand_reg_idx];
    assign emit_empty = (count_reg == '0);
    assign emit_last  = emit_empty || ((emit_reg + SC_W'(1)) == count_reg);
    assign out_free   = !out_valid || out_ready;

    // wall map: load write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && (load_pos_reg < total)) begin
            wall_mem[load_pos_reg[IDX_W-1:0]] <= in_wall;
        end
        if (op == OP_SCAN_RD) begin
            wall_rd_reg <= wall_mem[scan_idx];
        end else if (op == OP_NB_RD) begin
            wall_rd_reg <= wall_mem[cand_idx];
        end
    end

    // flood queue
    always_ff @(posedge aclk) begin
        if (op == OP_SCAN_TEST && scan_open) begin
            queue_mem[0] <= {scan_r_reg, scan_c_reg};
        end else if (op == OP_NB_TEST && nb_open) begin
            queue_mem[tail_reg[IDX_W-1:0]] <= {cand_r_reg, cand_c_reg};
        end
        if (op == OP_POP_RD) begin
            q_rd_reg <= queue_mem[head_reg[IDX_W-1:0]];
        end
    end

    // sorted size list
    always_ff @(posedge aclk) begin
        if (op == OP_INS_RD && k_reg == '0) begin
            size_mem[0] <= region_size_reg;
        end else if (op == OP_INS_CMP) begin
            size_mem[k_reg[SA_W-1:0]] <= (sz_rd_reg > region_size_reg) ?
                                         sz_rd_reg : region_size_reg;
        end
        if (op == OP_INS_RD) begin
            sz_rd_reg <= size_mem[SA_W'(k_reg - SC_W'(1))];
        end else if (op == OP_EMIT_RD) begin
            sz_rd_reg <= size_mem[emit_reg[SA_W-1:0]];
        end
    end

    // control counters and visited bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            visited_reg  <= '0;
            count_reg    <= '0;
            out_valid    <= 1'b0;
        end else begin
            // output register: load a size or drop the one taken
            if (op == OP_EMIT_WAIT && out_free) begin
                out_valid <= 1'b1;
            end else if (out_valid && out_ready) begin
                out_valid <= 1'b0;
            end
            case (op)
                OP_LOAD: begin
                    if (accept) begin
                        if (in_last) begin
                            load_pos_reg <= '0;
                            visited_reg  <= '0;
                            count_reg    <= '0;
                            emit_reg     <= '0;
                            scan_r_reg   <= '0;
                            scan_c_reg   <= '0;
                        end else if (load_pos_reg < total) begin
                            load_pos_reg <= load_pos_reg + LP_W'(1);
                        end
                    end
                end
                OP_SCAN_TEST: begin
                    if (scan_open) begin
                        visited_reg[scan_idx] <= 1'b1;
                        head_reg        <= '0;
                        tail_reg        <= LP_W'(1);
                        region_size_reg <= '0;
                    end
                end
                OP_SCAN_ADV: begin
                    if ((DIM_W'(scan_c_reg) + DIM_W'(1)) < nc) begin
                        scan_c_reg <= scan_c_reg + CW'(1);
                    end else begin
                        scan_c_reg <= '0;
                        scan_r_reg <= scan_r_reg + RW'(1);
                    end
                end
                OP_POP_RD: begin
                    if (head_reg != tail_reg) head_reg <= head_reg + LP_W'(1);
                    else k_reg <= count_reg;
                end
                OP_POP_WAIT: begin
                    cur_r_reg       <= q_rd_reg[QW-1:CW];
                    cur_c_reg       <= q_rd_reg[CW-1:0];
                    region_size_reg <= region_size_reg + SIZE_W'(1);
                    dir_reg         <= '0;
                end
                OP_NB_RD: begin
                    cand_r_reg <= nb_r;
                    cand_c_reg <= nb_c;
                    if (!nb_ok) dir_reg <= dir_reg + 2'd1;
                end
                OP_NB_TEST: begin
                    if (nb_open) begin
                        visited_reg[cand_reg_idx] <= 1'b1;
                        tail_reg <= tail_reg + LP_W'(1);
                    end
                    dir_reg <= dir_reg + 2'd1;
                end
                OP_INS_RD: begin
                    if (k_reg == '0) count_reg <= count_reg + SC_W'(1);
                end
                OP_INS_CMP: begin
                    if (sz_rd_reg > region_size_reg) k_reg <= k_reg - SC_W'(1);
                    else count_reg <= count_reg + SC_W'(1);
                end
                OP_EMIT_WAIT: begin
                    if (out_free) begin
                        out_size  <= emit_empty ? '0 : sz_rd_reg;
                        out_last  <= emit_last;
                        emit_reg  <= emit_reg + SC_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // status bundle
    always_comb begin
        st.frame_go    = accept && in_last;
        st.scan_open   = scan_open;
        st.scan_done   = ((DIM_W'(scan_c_reg) + DIM_W'(1)) >= nc) &&
                         ((DIM_W'(scan_r_reg) + DIM_W'(1)) >= nr);
        st.q_empty     = (head_reg == tail_reg);
        st.nb_ok       = nb_ok;
        st.dir_last    = (dir_reg == 2'd3);
        st.ins_zero    = (k_reg == '0);
        st.ins_greater = (sz_rd_reg > region_size_reg);
        st.emit_last   = emit_last;
        st.out_free    = out_free;
    end

endmodule

`default_nettype wire

// ===== rtl/core/grid_component_sizes_sorted.sv =====
// ----------------------------------------------------------------------------
// grid_component_sizes_sorted: sorted open-region sizes of a floor map
// Loads a wall/open map, floods 4-connected regions and lists sizes sorted.
// ----------------------------------------------------------------------------
// Cells arrive one per cycle in row-major order (tdata bit 0 = wall, tlast on
// the final cell). After the final cell the block scans the map, floods each
// unvisited open region breadth-first and insertion-sorts its size into a
// list; it then sends the sizes in ascending order, tlast on the last one, or
// a single 0 when no cell is open. No cell is taken during that work. The
// work scans each cell, pops each region cell and checks the queue for empty
// once per region, skips each off-grid neighbor direction and reads the
// single-port wall map for each on-grid one, steps through the size list on
// each insertion and sends each size, holding while the receiver stalls.
// rows and cols must be written only while idle; the block does not enforce
// this. They are clamped to 1..MAX_ROWS and 1..MAX_COLS.
`default_nettype none

module grid_component_sizes_sorted #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_we,
    input  wire logic [gcs_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [gcs_pkg::DIM_W-1:0]      cfg_wdata,
    // cell requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gcs_pkg::S_DATA_W-1:0]   s_tdata,   // [0] is_wall
    input  wire logic                           s_tlast,   // last_cell
    // size results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [gcs_pkg::M_DATA_W-1:0]        m_tdata,   // [6:0] room_size
    output logic                                m_tlast    // last_size
);
    import gcs_pkg::*;

    dp_op_t            op;
    dp_status_t        st;
    logic              load_ready;
    logic [SIZE_W-1:0] out_size;

    gcs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .st         (st),
        .op         (op),
        .load_ready (load_ready)
    );

    gcs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .in_valid  (s_tvalid),
        .in_wall   (s_tdata[0]),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_size  (out_size),
        .out_last  (m_tlast),
        .st        (st)
    );

    assign s_tready = load_ready;
    assign m_tdata  = M_DATA_W'(out_size);

endmodule

`default_nettype wire
